@@ design/qgh_pkg.sv @@
package qgh_pkg;

  // stream payload widths, padded to whole bytes
  localparam int unsigned IN_TDATA_W  = 80;
  localparam int unsigned OUT_TDATA_W = 80;

  // config register indexes
  localparam int unsigned CFG_AW = 2;
  localparam logic [CFG_AW-1:0] CFG_ORIGIN_LAT   = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_ORIGIN_LON   = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_CELLS_PER_DEG = 2'd2;
  localparam logic [CFG_AW-1:0] CFG_K_THRESHOLD  = 2'd3;

  localparam logic [31:0] CPD_RESET = 32'h0001_0000;
  localparam logic [31:0] K_RESET   = 32'd1;

  // Q9.22 offset times Q16.16 scale -> drop 38 fraction bits
  localparam int unsigned PROD_W     = 64;
  localparam int unsigned FRAC_SHIFT = 38;

  // control bits that ride along the cell chain with each transaction
  typedef struct packed {
    logic valid;
    logic query;
    logic active;
    logic found;
  } tok_ctrl_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BUSY
  } state_t;

  // cells per side at a pyramid level: ceil(grid / 2^lvl)
  function automatic int unsigned level_side(int unsigned grid, int unsigned lvl);
    return (grid + (32'd1 << lvl) - 32'd1) >> lvl;
  endfunction

endpackage

@@ design/quadtree_grid_histogram_cloak.sv @@
// Quadtree point-count pyramid with k-anonymity cloak lookup.
// Input stream (in_*): one transaction per item; in_tuser is the kind (0 add a
// point, 1 query a cell). Result stream (out_*): exactly one transaction per
// input item, in order; out_tuser is the status (1 = out of grid range).
// Config port (cfg_*): write origin_lat, origin_lon, cells_per_degree and
// k_threshold by index; writes take effect at once, intended while idle.
// Structure: a two-stage quantizer, then a chain of LEVELS cells, one per
// pyramid level, each owning its level's counter RAM. A transaction passes two
// registered steps in every cell (synchronous read, then compare / write-back).
// One item is in flight at a time: the next is taken only once the previous
// one has left the cell chain and the result holding stage is empty.
// Reset: config returns to defaults and every cell RAM is zeroed by a clearing
// pass over GRID_CELLS*GRID_CELLS addresses (4096 at 64x64), in_tready low.
// Stall: a finished result waits in the output register while the next item
// is accepted and worked on; a second result then waits in a holding stage,
// and no further item is taken until it moves on.
module quadtree_grid_histogram_cloak #(
  parameter int unsigned GRID_CELLS = 64,
  parameter int unsigned LEVELS     = 7,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // point_lat[31:0], point_lon[63:32], query_level[66:64], query_row[72:67],
  // query_column[78:73], zero pad [79]
  input  logic [qgh_pkg::IN_TDATA_W-1:0]  in_tdata,
  // kind[0]
  input  logic [0:0]                      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // cell_row[5:0], cell_column[11:6], cell_count[43:12], cloak_found[44],
  // cloak_level[47:45], cloak_density[79:48]
  output logic [qgh_pkg::OUT_TDATA_W-1:0] out_tdata,
  // status[0]
  output logic [0:0]                      out_tuser,
  input  logic                            cfg_we,
  input  logic [qgh_pkg::CFG_AW-1:0]      cfg_addr,
  input  logic [31:0]                     cfg_wdata
);
  import qgh_pkg::*;

  localparam int unsigned RW = $clog2(GRID_CELLS);
  localparam int unsigned LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int unsigned CW = $clog2(GRID_CELLS * GRID_CELLS);

  // config
  logic [31:0] origin_lat_r;
  logic [31:0] origin_lon_r;
  logic [31:0] cpd_r;
  logic [31:0] k_r;

  // control
  state_t       state_r, state_nxt;
  logic [CW-1:0] clr_r;
  logic          clr_en;
  logic          accept;
  logic          start_r;

  // item
  logic        kind_r;
  logic [31:0] lat_r;
  logic [31:0] lon_r;
  logic [2:0]  qlvl_r;
  logic [5:0]  qrow_r;
  logic [5:0]  qcol_r;

  logic          q_done;
  logic          q_ok;
  logic [RW-1:0] q_row;
  logic [RW-1:0] q_col;
  int unsigned   q_side;
  logic          q_bad;

  logic [5:0] echo_row_r;
  logic [5:0] echo_col_r;

  // chain taps, element g feeds cell g
  tok_ctrl_t             ch_ctrl    [LEVELS+1];
  logic [RW-1:0]         ch_row     [LEVELS+1];
  logic [RW-1:0]         ch_col     [LEVELS+1];
  logic [LW-1:0]         ch_start   [LEVELS+1];
  logic [COUNT_BITS-1:0] ch_count   [LEVELS+1];
  logic [LW-1:0]         ch_clevel  [LEVELS+1];
  logic [COUNT_BITS-1:0] ch_density [LEVELS+1];

  // result holding stage and output register
  logic        pend_valid_r;
  logic        pend_status_r;
  logic [31:0] pend_count_r;
  logic        pend_found_r;
  logic [2:0]  pend_clevel_r;
  logic [31:0] pend_density_r;
  logic        load;
  logic        out_valid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic        out_tuser_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_lat_r <= '0;
      origin_lon_r <= '0;
      cpd_r        <= CPD_RESET;
      k_r          <= K_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_ORIGIN_LAT:    origin_lat_r <= cfg_wdata;
        CFG_ORIGIN_LON:    origin_lon_r <= cfg_wdata;
        CFG_CELLS_PER_DEG: cpd_r        <= cfg_wdata;
        CFG_K_THRESHOLD:   k_r          <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      start_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= accept;
      if (clr_en) begin
        clr_r <= clr_r + 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    clr_en    = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        clr_en = 1'b1;
        if (clr_r == CW'(GRID_CELLS * GRID_CELLS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = !pend_valid_r;
        if (in_tvalid && !pend_valid_r) begin
          state_nxt = ST_BUSY;
        end
      end
      ST_BUSY: begin
        if (ch_ctrl[LEVELS].valid) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  assign accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_tuser[0];
      lat_r  <= in_tdata[31:0];
      lon_r  <= in_tdata[63:32];
      qlvl_r <= in_tdata[66:64];
      qrow_r <= in_tdata[72:67];
      qcol_r <= in_tdata[78:73];
    end
  end

  qgh_quant #(
    .GRID_CELLS(GRID_CELLS),
    .RW        (RW)
  ) u_quant (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start_r),
    .point_lat       (lat_r),
    .point_lon       (lon_r),
    .origin_lat      (origin_lat_r),
    .origin_lon      (origin_lon_r),
    .cells_per_degree(cpd_r),
    .done            (q_done),
    .ok              (q_ok),
    .row             (q_row),
    .col             (q_col)
  );

  assign q_side = level_side(GRID_CELLS, int'(qlvl_r));
  assign q_bad  = (int'(qlvl_r) >= int'(LEVELS)) || (int'(qrow_r) >= int'(q_side)) ||
                  (int'(qcol_r) >= int'(q_side));

  // chain entry: an add starts at the finest level, a query at its own level
  assign ch_ctrl[0]    = '{valid: q_done, query: kind_r,
                           active: kind_r ? !q_bad : q_ok, found: 1'b0};
  assign ch_row[0]     = kind_r ? RW'(qrow_r) : q_row;
  assign ch_col[0]     = kind_r ? RW'(qcol_r) : q_col;
  assign ch_start[0]   = kind_r ? LW'(qlvl_r) : '0;
  assign ch_count[0]   = '0;
  assign ch_clevel[0]  = '0;
  assign ch_density[0] = '0;

  always_ff @(posedge clk) begin
    if (q_done) begin
      echo_row_r <= kind_r ? qrow_r : (q_ok ? 6'(q_row) : 6'd0);
      echo_col_r <= kind_r ? qcol_r : (q_ok ? 6'(q_col) : 6'd0);
    end
  end

  for (genvar g = 0; g < LEVELS; g++) begin : g_level
    qgh_cell #(
      .GRID_CELLS(GRID_CELLS),
      .LEVEL     (g),
      .COUNT_BITS(COUNT_BITS),
      .RW        (RW),
      .LW        (LW),
      .CW        (CW)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .clr_en     (clr_en),
      .clr_addr   (clr_r),
      .k_threshold(k_r),
      .in_ctrl    (ch_ctrl[g]),
      .in_row     (ch_row[g]),
      .in_col     (ch_col[g]),
      .in_start   (ch_start[g]),
      .in_count   (ch_count[g]),
      .in_clevel  (ch_clevel[g]),
      .in_density (ch_density[g]),
      .out_ctrl   (ch_ctrl[g+1]),
      .out_row    (ch_row[g+1]),
      .out_col    (ch_col[g+1]),
      .out_start  (ch_start[g+1]),
      .out_count  (ch_count[g+1]),
      .out_clevel (ch_clevel[g+1]),
      .out_density(ch_density[g+1])
    );
  end

  assign load = pend_valid_r && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (ch_ctrl[LEVELS].valid) begin
        pend_valid_r <= 1'b1;
      end else if (load) begin
        pend_valid_r <= 1'b0;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ch_ctrl[LEVELS].valid) begin
      pend_status_r  <= !ch_ctrl[LEVELS].active;
      pend_count_r   <= 32'(ch_count[LEVELS]);
      pend_found_r   <= ch_ctrl[LEVELS].found;
      pend_clevel_r  <= 3'(ch_clevel[LEVELS]);
      pend_density_r <= 32'(ch_density[LEVELS]);
    end
    if (load) begin
      out_tdata_r <= {pend_density_r, pend_clevel_r, pend_found_r, pend_count_r,
                      echo_col_r, echo_row_r};
      out_tuser_r <= pend_status_r;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_tdata_r;
  assign out_tuser[0] = out_tuser_r;

`ifndef SYNTHESIS
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready)
    else $error("second transaction taken while one is in flight");
  a_chain_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ch_ctrl[LEVELS].valid |-> (state_r == ST_BUSY) && !pend_valid_r)
    else $error("chain result with no room or no item in flight");
  a_bad_is_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r && pend_status_r |->
      (pend_count_r == '0) && !pend_found_r && (pend_density_r == '0))
    else $error("out of range result carries data");
`endif

endmodule

@@ design/qgh_quant.sv @@
module qgh_quant #(
  parameter int unsigned GRID_CELLS = 64,
  parameter int unsigned RW         = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [31:0]   point_lat,
  input  logic [31:0]   point_lon,
  input  logic [31:0]   origin_lat,
  input  logic [31:0]   origin_lon,
  input  logic [31:0]   cells_per_degree,
  output logic          done,
  output logic          ok,
  output logic [RW-1:0] row,
  output logic [RW-1:0] col
);
  import qgh_pkg::*;

  localparam int unsigned IDXW = PROD_W - FRAC_SHIFT;

  logic              v1_r;
  logic              v2_r;
  logic [32:0]       dlat_r;
  logic [32:0]       dlon_r;
  logic [PROD_W-1:0] prod_lat_r;
  logic [PROD_W-1:0] prod_lon_r;
  logic              neg_r;
  logic [IDXW-1:0]   idx_lat;
  logic [IDXW-1:0]   idx_lon;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
    end
  end

  // exact signed offset, then one 32x32 multiply per axis
  always_ff @(posedge clk) begin
    dlat_r     <= {point_lat[31], point_lat} - {origin_lat[31], origin_lat};
    dlon_r     <= {point_lon[31], point_lon} - {origin_lon[31], origin_lon};
    prod_lat_r <= PROD_W'(dlat_r[31:0]) * PROD_W'(cells_per_degree);
    prod_lon_r <= PROD_W'(dlon_r[31:0]) * PROD_W'(cells_per_degree);
    neg_r      <= dlat_r[32] | dlon_r[32];
  end

  assign idx_lat = prod_lat_r[PROD_W-1:FRAC_SHIFT];
  assign idx_lon = prod_lon_r[PROD_W-1:FRAC_SHIFT];

  assign done = v2_r;
  assign ok   = !neg_r && (idx_lat < IDXW'(GRID_CELLS)) && (idx_lon < IDXW'(GRID_CELLS));
  assign row  = prod_lat_r[FRAC_SHIFT +: RW];
  assign col  = prod_lon_r[FRAC_SHIFT +: RW];

endmodule

@@ design/qgh_cell.sv @@
module qgh_cell #(
  parameter int unsigned GRID_CELLS = 64,
  parameter int unsigned LEVEL      = 0,
  parameter int unsigned COUNT_BITS = 32,
  parameter int unsigned RW         = 6,
  parameter int unsigned LW         = 3,
  parameter int unsigned CW         = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   clr_en,
  input  logic [CW-1:0]          clr_addr,
  input  logic [31:0]            k_threshold,
  input  qgh_pkg::tok_ctrl_t     in_ctrl,
  input  logic [RW-1:0]          in_row,
  input  logic [RW-1:0]          in_col,
  input  logic [LW-1:0]          in_start,
  input  logic [COUNT_BITS-1:0]  in_count,
  input  logic [LW-1:0]          in_clevel,
  input  logic [COUNT_BITS-1:0]  in_density,
  output qgh_pkg::tok_ctrl_t     out_ctrl,
  output logic [RW-1:0]          out_row,
  output logic [RW-1:0]          out_col,
  output logic [LW-1:0]          out_start,
  output logic [COUNT_BITS-1:0]  out_count,
  output logic [LW-1:0]          out_clevel,
  output logic [COUNT_BITS-1:0]  out_density
);
  import qgh_pkg::*;

  localparam int unsigned SIDE  = level_side(GRID_CELLS, LEVEL);
  localparam int unsigned DEPTH = SIDE * SIDE;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned KW    = (COUNT_BITS > 32) ? COUNT_BITS : 32;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic [COUNT_BITS-1:0] mem [DEPTH];

  logic                  acts;
  logic [AW-1:0]         rd_addr;
  logic                  clr_hit;
  logic                  wr_en;
  logic                  at_start;
  logic                  reach;
  logic [COUNT_BITS-1:0] inc_val;

  tok_ctrl_t             s0_ctrl_r;
  logic                  s0_act_r;
  logic [RW-1:0]         s0_row_r;
  logic [RW-1:0]         s0_col_r;
  logic [LW-1:0]         s0_start_r;
  logic [COUNT_BITS-1:0] s0_count_r;
  logic [LW-1:0]         s0_clevel_r;
  logic [COUNT_BITS-1:0] s0_density_r;
  logic [AW-1:0]         s0_addr_r;
  logic [COUNT_BITS-1:0] rd_data_r;

  tok_ctrl_t             ctrl_nxt, ctrl_r;
  logic [RW-1:0]         row_nxt, row_r;
  logic [RW-1:0]         col_nxt, col_r;
  logic [COUNT_BITS-1:0] count_nxt, count_r;
  logic [LW-1:0]         clevel_nxt, clevel_r;
  logic [COUNT_BITS-1:0] density_nxt, density_r;
  logic [LW-1:0]         start_r;

  // a query walks up from its own level; an add touches every level
  assign acts    = in_ctrl.valid && in_ctrl.active && (int'(in_start) <= int'(LEVEL));
  assign rd_addr = AW'(int'(in_row) * int'(SIDE) + int'(in_col));
  assign clr_hit = int'(clr_addr) < int'(DEPTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_ctrl_r <= '0;
      s0_act_r  <= 1'b0;
    end else begin
      s0_ctrl_r <= in_ctrl;
      s0_act_r  <= acts;
    end
  end

  always_ff @(posedge clk) begin
    s0_row_r     <= in_row;
    s0_col_r     <= in_col;
    s0_start_r   <= in_start;
    s0_count_r   <= in_count;
    s0_clevel_r  <= in_clevel;
    s0_density_r <= in_density;
    s0_addr_r    <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (clr_en && clr_hit) begin
      mem[AW'(clr_addr)] <= '0;
    end else if (wr_en) begin
      mem[s0_addr_r] <= inc_val;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign inc_val  = (rd_data_r == COUNT_MAX) ? rd_data_r : rd_data_r + 1'b1;
  assign at_start = int'(s0_start_r) == int'(LEVEL);
  assign reach    = KW'(rd_data_r) >= KW'(k_threshold);
  assign wr_en    = s0_act_r && !s0_ctrl_r.query;

  always_comb begin
    ctrl_nxt    = s0_ctrl_r;
    row_nxt     = s0_row_r;
    col_nxt     = s0_col_r;
    count_nxt   = s0_count_r;
    clevel_nxt  = s0_clevel_r;
    density_nxt = s0_density_r;
    if (s0_act_r) begin
      row_nxt = s0_row_r >> 1;
      col_nxt = s0_col_r >> 1;
      if (at_start) begin
        count_nxt = s0_ctrl_r.query ? rd_data_r : inc_val;
      end
      if (s0_ctrl_r.query && !s0_ctrl_r.found && reach) begin
        ctrl_nxt.found = 1'b1;
        clevel_nxt     = LW'(LEVEL);
        density_nxt    = rd_data_r >> (2 * LEVEL);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else begin
      ctrl_r <= ctrl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r     <= row_nxt;
    col_r     <= col_nxt;
    start_r   <= s0_start_r;
    count_r   <= count_nxt;
    clevel_r  <= clevel_nxt;
    density_r <= density_nxt;
  end

  assign out_ctrl    = ctrl_r;
  assign out_row     = row_r;
  assign out_col     = col_r;
  assign out_start   = start_r;
  assign out_count   = count_r;
  assign out_clevel  = clevel_r;
  assign out_density = density_r;

`ifndef SYNTHESIS
  a_pass_two: assert property (@(posedge clk) disable iff (!rst_n)
    in_ctrl.valid |-> ##2 out_ctrl.valid)
    else $error("cell dropped a transaction");
  a_found_kept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ctrl.valid && in_ctrl.found |-> ##2 out_ctrl.found)
    else $error("cloak hit lost in cell");
  a_no_write_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_en |-> !wr_en)
    else $error("counter update during clearing pass");
`endif

endmodule

@@ bench/qgh_tb_pkg.sv @@
`timescale 1ns / 100ps
package qgh_tb_pkg;

  typedef enum logic [0:0] {
    KIND_ADD   = 1'b0,
    KIND_QUERY = 1'b1
  } item_kind_t;

  typedef enum logic [0:0] {
    STATUS_OK    = 1'b0,
    STATUS_RANGE = 1'b1
  } result_status_t;

endpackage

@@ bench/cloak_checker.sv @@
`timescale 1ns / 100ps
module cloak_checker
  import qgh_pkg::*, qgh_tb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [0:0]             in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic [0:0]             out_tuser,
  input  logic                   cfg_we,
  input  logic [CFG_AW-1:0]      cfg_addr,
  input  logic [31:0]            cfg_wdata,
  output int                     fail_count,
  output int                     pending,
  output int                     n_adds,
  output int                     n_dropped,
  output int                     n_queries,
  output int                     n_bad_queries,
  output int                     n_cloaked
);

  localparam int GRID = 64;
  localparam int NLEV = 7;

  typedef struct {
    result_status_t status;
    logic [5:0]     row;
    logic [5:0]     col;
    logic [31:0]    count;
    logic           found;
    logic [2:0]     level;
    logic [31:0]    density;
  } cell_report_t;

  // one counter plane per level, addressed row * GRID + col
  logic [31:0]        counts [0:NLEV-1][0:GRID*GRID-1];
  logic signed [31:0] org_lat;
  logic signed [31:0] org_lon;
  logic [31:0]        scale;
  logic [31:0]        k_min;
  cell_report_t       expected_reports [$];
  cell_report_t       want;
  cell_report_t       seen;

  function automatic int unsigned side(input int unsigned lvl);
    return (GRID + (1 << lvl) - 1) >> lvl;
  endfunction

  function automatic int slot(input logic [5:0] row, input logic [5:0] col);
    return int'(row) * GRID + int'(col);
  endfunction

  function automatic logic quantize(input logic [31:0] point, input logic [31:0] origin,
                                    output logic [5:0] idx);
    longint     diff;
    logic [63:0] prod;
    idx = '0;
    diff = longint'($signed(point)) - longint'($signed(origin));
    if (diff < 0) return 1'b0;
    // Q9.22 offset times Q16.16 scale
    prod = (64'(diff) * 64'(scale)) >> FRAC_SHIFT;
    if (prod >= GRID) return 1'b0;
    idx = prod[5:0];
    return 1'b1;
  endfunction

  task automatic predict_report(input logic [0:0] kind, input logic [IN_TDATA_W-1:0] item,
                                output cell_report_t rep);
    logic [5:0]  r;
    logic [5:0]  c;
    logic [2:0]  ql;
    logic        in_r;
    logic        in_c;
    int unsigned up;
    logic [31:0] v;
    rep = '{STATUS_OK, 6'd0, 6'd0, 32'd0, 1'b0, 3'd0, 32'd0};
    if (kind == KIND_ADD) begin
      n_adds++;
      in_r = quantize(item[31:0], org_lat, r);
      in_c = quantize(item[63:32], org_lon, c);
      if (in_r && in_c) begin
        for (int l = 0; l < NLEV; l++) begin
          if (counts[l][slot(r >> l, c >> l)] != '1)
            counts[l][slot(r >> l, c >> l)]++;
        end
        rep.row = r;
        rep.col = c;
        rep.count = counts[0][slot(r, c)];
      end else begin
        rep.status = STATUS_RANGE;
        n_dropped++;
      end
    end else begin
      n_queries++;
      ql = item[66:64];
      r = item[72:67];
      c = item[78:73];
      rep.row = r;
      rep.col = c;
      if (ql >= NLEV || r >= side(ql) || c >= side(ql)) begin
        rep.status = STATUS_RANGE;
        n_bad_queries++;
      end else begin
        rep.count = counts[ql][slot(r, c)];
        // walk up from the cell through its ancestors until one holds at least k points
        for (int l = int'(ql); l < NLEV; l++) begin
          up = l - ql;
          v = counts[l][slot(r >> up, c >> up)];
          if (v >= k_min) begin
            rep.found = 1'b1;
            rep.level = 3'(l);
            rep.density = v >> (2 * l);
            n_cloaked++;
            break;
          end
        end
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      org_lat = '0;
      org_lon = '0;
      scale = CPD_RESET;
      k_min = K_RESET;
      for (int l = 0; l < NLEV; l++)
        for (int i = 0; i < GRID * GRID; i++)
          counts[l][i] = '0;
      expected_reports.delete();
      pending = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_reports.size() == 0) begin
          $error("result transaction with no item outstanding");
          fail_count++;
        end else begin
          want = expected_reports.pop_front();
          check_field("status", 32'(want.status), 32'(out_tuser));
          check_field("cell_row", 32'(want.row), 32'(out_tdata[5:0]));
          check_field("cell_column", 32'(want.col), 32'(out_tdata[11:6]));
          check_field("cell_count", want.count, out_tdata[43:12]);
          check_field("cloak_found", 32'(want.found), 32'(out_tdata[44]));
          check_field("cloak_level", 32'(want.level), 32'(out_tdata[47:45]));
          check_field("cloak_density", want.density, out_tdata[79:48]);
        end
      end
      if (cfg_we) begin
        case (cfg_addr)
          CFG_ORIGIN_LAT:    org_lat = cfg_wdata;
          CFG_ORIGIN_LON:    org_lon = cfg_wdata;
          CFG_CELLS_PER_DEG: scale = cfg_wdata;
          CFG_K_THRESHOLD:   k_min = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        predict_report(in_tuser, in_tdata, seen);
        expected_reports = {expected_reports, seen};
      end
      pending = expected_reports.size();
    end
  end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
module testbench;
  import qgh_pkg::*;
  import qgh_tb_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 2 * 7 + 8;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [0:0]             in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [0:0]             out_tuser;
  logic                   cfg_we;
  logic [CFG_AW-1:0]      cfg_addr;
  logic [31:0]            cfg_wdata;

  int fail_count;
  int pending;
  int n_adds;
  int n_dropped;
  int n_queries;
  int n_bad_queries;
  int n_cloaked;

  int          idle_cycles = 0;
  int          settings_used = 1;
  bit          src_gaps = 1'b1;
  bit          sink_stalls = 1'b1;
  logic [31:0] cur_lat_org = '0;
  logic [31:0] cur_lon_org = '0;
  logic [31:0] cur_cpd = CPD_RESET;

  quadtree_grid_histogram_cloak u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  cloak_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending       (pending),
    .n_adds        (n_adds),
    .n_dropped     (n_dropped),
    .n_queries     (n_queries),
    .n_bad_queries (n_bad_queries),
    .n_cloaked     (n_cloaked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result side back-pressure
  initial begin
    int stall;
    stall = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
        if (sink_stalls && $urandom_range(0, 99) < 30) stall = pick_gap();
      end
    end
  end

  // ends the run if neither channel moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(input item_kind_t kind, input logic [31:0] lat,
                           input logic [31:0] lon, input logic [2:0] lvl,
                           input logic [5:0] row, input logic [5:0] col);
    int gap;
    gap = src_gaps ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {1'b0, col, row, lvl, lon, lat};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // query fields are don't-care on an add, so they get random bits
  task automatic send_add(input logic [31:0] lat, input logic [31:0] lon);
    send_item(KIND_ADD, lat, lon, 3'($urandom()), 6'($urandom()), 6'($urandom()));
  endtask

  task automatic send_query(input logic [2:0] lvl, input logic [5:0] row, input logic [5:0] col);
    send_item(KIND_QUERY, $urandom(), $urandom(), lvl, row, col);
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [31:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_setting(input logic [31:0] lat_org, input logic [31:0] lon_org,
                               input logic [31:0] cpd, input logic [31:0] k);
    drain();
    write_reg(CFG_ORIGIN_LAT, lat_org);
    write_reg(CFG_ORIGIN_LON, lon_org);
    write_reg(CFG_CELLS_PER_DEG, cpd);
    write_reg(CFG_K_THRESHOLD, k);
    cur_lat_org = lat_org;
    cur_lon_org = lon_org;
    cur_cpd = cpd;
    settings_used++;
  endtask

  // mostly lands in the grid, biased to the low corner so queries see counts
  function automatic logic [31:0] aim_point(input logic [31:0] origin);
    longint span;
    longint offs;
    int     r;
    span = (cur_cpd == 0) ? 64'hFFFF_FFFF : (longint'(64) << FRAC_SHIFT) / cur_cpd;
    if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
    if (span < 8) span = 8;
    r = $urandom_range(0, 99);
    if (r < 40) offs = longint'($urandom_range(0, 32'(span / 8)));
    else if (r < 75) offs = longint'($urandom_range(0, 32'(span - 1)));
    else if (r < 85) offs = span + longint'($urandom_range(0, 32'(span / 8)));
    else if (r < 92) offs = -longint'($urandom_range(1, 32'(span / 8 + 1)));
    else return $urandom();
    return 32'(longint'($signed(origin)) + offs);
  endfunction

  task automatic send_random_query();
    logic [2:0]  lvl;
    logic [5:0]  row;
    logic [5:0]  col;
    int unsigned sd;
    int unsigned near;
    int          r;
    lvl = ($urandom_range(0, 19) == 0) ? 3'd7 : 3'($urandom_range(0, 6));
    sd = (64 + (1 << lvl) - 1) >> lvl;
    near = (sd < 8) ? sd : 8;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      row = 6'($urandom_range(0, near - 1));
      col = 6'($urandom_range(0, near - 1));
    end else if (r < 85) begin
      row = 6'($urandom_range(0, sd - 1));
      col = 6'($urandom_range(0, sd - 1));
    end else begin
      row = 6'($urandom_range(0, 63));
      col = 6'($urandom_range(0, 63));
    end
    send_query(lvl, row, col);
  endtask

  task automatic random_items(input int n);
    repeat (n) begin
      if ($urandom_range(0, 99) < 55) send_add(aim_point(cur_lat_org), aim_point(cur_lon_org));
      else send_random_query();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed, reset config: one cell per degree from the origin, k = 1
    send_query(3'd0, 6'd5, 6'd5);                 // empty store, no cloak anywhere
    send_add(32'h0000_0000, 32'h0000_0000);
    send_add(32'h0000_0000, 32'h0000_0000);
    send_add(32'h0FFF_FFFF, 32'h0FFF_FFFF);       // far corner cell
    send_add(32'h1000_0000, 32'h0000_0000);       // one cell past the edge
    send_add(32'hFFFF_FFFF, 32'h0000_0000);       // just below the origin
    send_add(32'h0000_0000, 32'h8000_0000);
    send_add(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_add(32'h0000_0000, 32'h0020_0000);
    send_add(32'h0030_0000, 32'h0000_0000);
    send_query(3'd0, 6'd0, 6'd0);
    send_query(3'd1, 6'd0, 6'd0);
    send_query(3'd6, 6'd0, 6'd0);
    send_query(3'd0, 6'd63, 6'd63);
    send_query(3'd1, 6'd31, 6'd31);
    send_query(3'd0, 6'd10, 6'd10);               // cloaked by its level 4 ancestor
    send_query(3'd5, 6'd1, 6'd1);
    send_query(3'd7, 6'd0, 6'd0);                 // no such level
    send_query(3'd3, 6'd8, 6'd0);                 // row past level side
    send_query(3'd6, 6'd0, 6'd1);                 // column past level side
    drain();
    write_reg(CFG_K_THRESHOLD, 32'd0);            // every cell cloaks itself
    send_query(3'd0, 6'd20, 6'd20);
    send_query(3'd2, 6'd0, 6'd0);
    drain();
    write_reg(CFG_K_THRESHOLD, 32'hFFFF_FFFF);    // nothing reaches k
    send_query(3'd6, 6'd0, 6'd0);
    send_query(3'd0, 6'd0, 6'd0);

    apply_setting(32'hFD80_0000, 32'h0140_0000, 32'h0004_0000, 32'd3);
    random_items(100);
    // scale of zero folds every point onto the first cell
    apply_setting(32'h8000_0000, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
    random_items(40);
    apply_setting(32'h7FFF_FFFF, 32'h7FFF_F000, 32'hFFFF_FFFF, 32'd0);
    send_add(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_add(32'h7FFF_FFFF, 32'h7FFF_F000);
    random_items(40);
    apply_setting(32'h0000_0000, 32'h0000_0000, 32'h0002_0000, 32'd5);
    src_gaps = 1'b0;
    sink_stalls = 1'b0;
    random_items(120);
    src_gaps = 1'b1;
    sink_stalls = 1'b1;
    apply_setting(32'h1000_0000, 32'hF000_0000, CPD_RESET, 32'd2);
    random_items(100);

    drain();
    $display("Covered %0d adds (%0d off grid) and %0d queries (%0d out of range, %0d cloaked)",
             n_adds, n_dropped, n_queries, n_bad_queries, n_cloaked);
    $display("over %0d register settings, with source gaps and sink stalls", settings_used);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/qgh_pkg.sv
design/qgh_quant.sv
design/qgh_cell.sv
design/quadtree_grid_histogram_cloak.sv
bench/qgh_tb_pkg.sv
bench/cloak_checker.sv
bench/testbench.sv
